// ----- rtl/core/unique_key_priority_queue_assert.svh -----
// Assertion macros for the priority queue block.
// Used by unique_key_priority_queue.sv; expects clk_i and rst_ni in scope.
`ifndef UNIQUE_KEY_PRIORITY_QUEUE_ASSERT_SVH
`define UNIQUE_KEY_PRIORITY_QUEUE_ASSERT_SVH

// Check that holds in the same cycle as the trigger
`define UKPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after the trigger
`define UKPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ukpq_pkg.sv -----
// Shared types and constants of the unique-key priority queue.
// No dependencies; used by the cell and the top level.
package ukpq_pkg;

  localparam int TAG_W     = 32;
  localparam int PRIO_W    = 32;
  localparam int POS_W     = 5;
  localparam int OUT_CNT_W = 5;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_RENAME = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_EMPTY = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_NOPOS = 3'd4
  } status_e;

  // Per-cell update selection
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_SHIFT_R,
    CELL_SHIFT_L,
    CELL_RENAME
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_REPORT
  } fsm_state_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [TAG_W-1:0]         name_tag;
    logic signed [PRIO_W-1:0] prio;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [TAG_W-1:0]         removed_tag;
    logic signed [PRIO_W-1:0] removed_prio;
    logic [OUT_CNT_W-1:0]     entry_count;
    logic                     head_valid;
    logic [TAG_W-1:0]         head_tag;
    logic signed [PRIO_W-1:0] head_prio;
    logic [OUT_CNT_W-1:0]     top_ties;
  } out_item_t;

  // Compare results a cell registers when an item is accepted
  typedef struct packed {
    logic match;  // occupied and tag equals request tag
    logic ge;     // occupied and priority >= request priority
  } cell_flags_t;

endpackage

// ----- rtl/core/ukpq_chan_if.sv -----
// Valid/ready channel carrying one item of a given type.
// Depends on nothing; item type is set where the channel is instantiated.
interface ukpq_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ukpq_cell.sv -----
// One storage cell of the sorted entry chain: tag, priority, compare flags.
// Depends on ukpq_pkg.
module ukpq_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmp_en_i,
  input  logic                                 occ_i,
  input  logic [ukpq_pkg::TAG_W-1:0]           cmp_tag_i,
  input  logic signed [ukpq_pkg::PRIO_W-1:0]   cmp_prio_i,
  input  logic signed [ukpq_pkg::PRIO_W-1:0]   head_prio_i,
  input  ukpq_pkg::cell_op_e                   op_i,
  input  logic [ukpq_pkg::TAG_W-1:0]           new_tag_i,
  input  logic signed [ukpq_pkg::PRIO_W-1:0]   new_prio_i,
  input  logic [ukpq_pkg::TAG_W-1:0]           left_tag_i,
  input  logic signed [ukpq_pkg::PRIO_W-1:0]   left_prio_i,
  input  logic [ukpq_pkg::TAG_W-1:0]           right_tag_i,
  input  logic signed [ukpq_pkg::PRIO_W-1:0]   right_prio_i,
  output logic [ukpq_pkg::TAG_W-1:0]           tag_o,
  output logic signed [ukpq_pkg::PRIO_W-1:0]   prio_o,
  output ukpq_pkg::cell_flags_t                flags_o,
  output logic                                 eq_o
);

  logic [ukpq_pkg::TAG_W-1:0]         tag_q, tag_d;
  logic signed [ukpq_pkg::PRIO_W-1:0] prio_q, prio_d;
  ukpq_pkg::cell_flags_t              flags_q, flags_d;

  // Entry update from request or neighbor
  always_comb begin
    tag_d  = tag_q;
    prio_d = prio_q;
    unique case (op_i)
      ukpq_pkg::CELL_HOLD: begin
      end
      ukpq_pkg::CELL_LOAD_NEW: begin
        tag_d  = new_tag_i;
        prio_d = new_prio_i;
      end
      ukpq_pkg::CELL_SHIFT_R: begin
        tag_d  = left_tag_i;
        prio_d = left_prio_i;
      end
      ukpq_pkg::CELL_SHIFT_L: begin
        tag_d  = right_tag_i;
        prio_d = right_prio_i;
      end
      ukpq_pkg::CELL_RENAME: begin
        tag_d = new_tag_i;
      end
      default: begin
      end
    endcase
  end

  // Compare against the incoming item
  always_comb begin
    flags_d = flags_q;
    if (cmp_en_i) begin
      flags_d.match = occ_i && (tag_q == cmp_tag_i);
      flags_d.ge    = occ_i && (prio_q >= cmp_prio_i);
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    prio_q <= prio_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign tag_o   = tag_q;
  assign prio_o  = prio_q;
  assign flags_o = flags_q;
  assign eq_o    = occ_i && (prio_q == head_prio_i);

endmodule

// ----- rtl/core/unique_key_priority_queue.sv -----
// Unique-key priority queue over a chain of CAPACITY cells kept in service order.
// A request is compared on accept, applied (shift/update) in APPLY and its result registered in REPORT.
// The next request can be accepted in REPORT, while the previous result is being registered.
// A waiting result holds the controller in report and stalls the input there until taken; idle still accepts a request.
// Reset clears the fill count, the controller, the result valid and the cell flags; cell tags and priorities stay.
// Depends on ukpq_pkg, ukpq_chan_if, ukpq_cell and unique_key_priority_queue_assert.svh.
`include "unique_key_priority_queue_assert.svh"

module unique_key_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ukpq_chan_if.sink   req_i,
  ukpq_chan_if.source rsp_o
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PCW = (CW > ukpq_pkg::POS_W) ? CW : ukpq_pkg::POS_W;

  ukpq_pkg::fsm_state_e state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  ukpq_pkg::in_item_t   req_q;
  ukpq_pkg::out_item_t  out_q;
  logic                 out_valid_q;

  logic [ukpq_pkg::TAG_W-1:0]         rem_tag_q, rem_tag_d;
  logic signed [ukpq_pkg::PRIO_W-1:0] rem_prio_q, rem_prio_d;
  ukpq_pkg::status_e                  status_q, status_d;

  logic in_fire, apply_en, report_en, out_free;
  logic do_ins, do_rem, do_ren;
  logic dup, full, empty, pos_bad;
  logic [PCW-1:0] pos_ext, cnt_ext;

  logic [ukpq_pkg::TAG_W-1:0]         tag_w  [CAPACITY];
  logic signed [ukpq_pkg::PRIO_W-1:0] prio_w [CAPACITY];
  ukpq_pkg::cell_flags_t              flags_w[CAPACITY];
  ukpq_pkg::cell_op_e                 op_w   [CAPACITY];
  logic [CAPACITY-1:0] occ, eq_vec, match_vec, take, load_vec, hit;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign in_fire  = req_i.valid && req_i.ready;

  // Controller next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ukpq_pkg::ST_IDLE: begin
        if (in_fire) state_d = ukpq_pkg::ST_APPLY;
      end
      ukpq_pkg::ST_APPLY: begin
        state_d = ukpq_pkg::ST_REPORT;
      end
      ukpq_pkg::ST_REPORT: begin
        if (out_free) state_d = in_fire ? ukpq_pkg::ST_APPLY : ukpq_pkg::ST_IDLE;
      end
      default: state_d = ukpq_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    req_i.ready = 1'b0;
    apply_en    = 1'b0;
    report_en   = 1'b0;
    unique case (state_q)
      ukpq_pkg::ST_IDLE:   req_i.ready = 1'b1;
      ukpq_pkg::ST_APPLY:  apply_en = 1'b1;
      ukpq_pkg::ST_REPORT: begin
        report_en   = out_free;
        req_i.ready = out_free;
      end
      default: begin
      end
    endcase
  end

  // Request decode against registered cell flags
  assign dup     = |match_vec;
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign pos_ext = PCW'(req_q.position);
  assign cnt_ext = PCW'(count_q);
  assign pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);

  always_comb begin
    status_d   = ukpq_pkg::STAT_OK;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_ren     = 1'b0;
    rem_tag_d  = '0;
    rem_prio_d = '0;
    count_d    = count_q;
    unique case (req_q.req_type)
      ukpq_pkg::REQ_INSERT: begin
        if (dup)       status_d = ukpq_pkg::STAT_DUP;
        else if (full) status_d = ukpq_pkg::STAT_FULL;
        else           do_ins = apply_en;
      end
      ukpq_pkg::REQ_REMOVE: begin
        if (empty) begin
          status_d = ukpq_pkg::STAT_EMPTY;
        end else begin
          do_rem     = apply_en;
          rem_tag_d  = tag_w[0];
          rem_prio_d = prio_w[0];
        end
      end
      ukpq_pkg::REQ_RENAME: begin
        if (empty)        status_d = ukpq_pkg::STAT_EMPTY;
        else if (pos_bad) status_d = ukpq_pkg::STAT_NOPOS;
        else if (dup)     status_d = ukpq_pkg::STAT_DUP;
        else              do_ren = apply_en;
      end
      default: begin
      end
    endcase
    if (do_ins) count_d = count_q + CW'(1);
    if (do_rem) count_d = count_q - CW'(1);
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ukpq_pkg::TAG_W-1:0]         left_tag, right_tag;
    logic signed [ukpq_pkg::PRIO_W-1:0] left_prio, right_prio;

    assign occ[i]       = (count_q > CW'(i));
    assign match_vec[i] = flags_w[i].match;
    assign take[i]      = !flags_w[i].ge;
    assign hit[i]       = (pos_ext == PCW'(i + 1));

    if (i == 0) begin : g_first
      assign left_tag    = req_q.name_tag;
      assign left_prio   = req_q.prio;
      assign load_vec[i] = take[i];
    end else begin : g_inner
      assign left_tag    = tag_w[i-1];
      assign left_prio   = prio_w[i-1];
      assign load_vec[i] = take[i] && !take[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_tag  = tag_w[i];
      assign right_prio = prio_w[i];
    end else begin : g_mid
      assign right_tag  = tag_w[i+1];
      assign right_prio = prio_w[i+1];
    end

    // On insert, cells at or past the insert point load or shift down; remove shifts all up; rename retags one
    always_comb begin
      op_w[i] = ukpq_pkg::CELL_HOLD;
      if (do_ins) begin
        if (take[i]) op_w[i] = load_vec[i] ? ukpq_pkg::CELL_LOAD_NEW : ukpq_pkg::CELL_SHIFT_R;
      end else if (do_rem) begin
        op_w[i] = ukpq_pkg::CELL_SHIFT_L;
      end else if (do_ren && hit[i]) begin
        op_w[i] = ukpq_pkg::CELL_RENAME;
      end
    end

    ukpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmp_en_i     (in_fire),
      .occ_i        (occ[i]),
      .cmp_tag_i    (req_i.data.name_tag),
      .cmp_prio_i   (req_i.data.prio),
      .head_prio_i  (prio_w[0]),
      .op_i         (op_w[i]),
      .new_tag_i    (req_q.name_tag),
      .new_prio_i   (req_q.prio),
      .left_tag_i   (left_tag),
      .left_prio_i  (left_prio),
      .right_tag_i  (right_tag),
      .right_prio_i (right_prio),
      .tag_o        (tag_w[i]),
      .prio_o       (prio_w[i]),
      .flags_o      (flags_w[i]),
      .eq_o         (eq_vec[i])
    );
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ukpq_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (report_en)        out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= req_i.data;
    if (apply_en) begin
      status_q   <= status_d;
      rem_tag_q  <= rem_tag_d;
      rem_prio_q <= rem_prio_d;
    end
    if (report_en) begin
      out_q.status       <= status_q;
      out_q.removed_tag  <= rem_tag_q;
      out_q.removed_prio <= rem_prio_q;
      out_q.entry_count  <= ukpq_pkg::OUT_CNT_W'(count_q);
      out_q.head_valid   <= !empty;
      out_q.head_tag     <= empty ? '0 : tag_w[0];
      out_q.head_prio    <= empty ? '0 : prio_w[0];
      out_q.top_ties     <= ukpq_pkg::OUT_CNT_W'($countones(eq_vec));
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  `UKPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "fill count above capacity")
  `UKPQ_ASSERT_NOW(a_one_insert_slot, do_ins, $onehot0(load_vec), "several insert points")
  `UKPQ_ASSERT_NEXT(a_insert_grows, do_ins, count_q == $past(count_q) + CW'(1), "insert lost")
  `UKPQ_ASSERT_NOW(a_rsp_after_report, $rose(out_valid_q), $past(report_en), "stray result")

endmodule
